[rtl/refcounted_type_presence_map_assert.svh]
// assertion macros for the type presence map
`ifndef REFCOUNTED_TYPE_PRESENCE_MAP_ASSERT_SVH
`define REFCOUNTED_TYPE_PRESENCE_MAP_ASSERT_SVH

// clocked check, off while reset is low
`define RTPM_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds through reset
`define RTPM_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/rtpm_pkg.sv]
// types and codes shared by the type presence map
package rtpm_pkg;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_TEST   = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_ZERO = 2'd2
    } status_t;

    typedef struct packed {
        status_t status;
        logic    pres;
        logic    flip;
        logic    hit;
        logic    wr_en;
    } upd_flags_t;

endpackage

[rtl/refcounted_type_presence_map.sv]
// reference counted presence map of message types, count memory with forwarding
//
//  channel | direction | handshake             | fields
//  --------+-----------+-----------------------+----------------------------------------
//  in      | input     | in_valid / in_stall   | opcode, type_id, last_in_set, empty_set
//  out     | output    | out_valid / out_stall | present, use_count, map_changed,
//          |           |                       | any_match, set_done, status
//
// one word per cycle sustained while out is not stalled; a taken word passes the memory
// read register, then the update and output register; a repeat of the same type is
// forwarded from the last write-back so the count read-modify-write keeps full rate.
// after reset a clearing pass writes zero to all TYPE_COUNT entries, one per cycle,
// with in_stall high until the pass is done.
// a stall on out holds the result register and, one word later, the input side.
module refcounted_type_presence_map
    import rtpm_pkg::*;
#(
    parameter int TYPE_COUNT = 65536,
    parameter int COUNT_BITS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [15:0] type_id,
    input  logic        last_in_set,
    input  logic        empty_set,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        present,
    output logic [7:0]  use_count,
    output logic        map_changed,
    output logic        any_match,
    output logic        set_done,
    output logic [1:0]  status
);

    `include "refcounted_type_presence_map_assert.svh"

    localparam int AW = $clog2(TYPE_COUNT);

    logic [COUNT_BITS-1:0] mem [TYPE_COUNT];
    logic [COUNT_BITS-1:0] rd_data_reg;

    logic                  clear_reg;
    logic [AW-1:0]         clr_addr_reg;

    logic                  s1_valid_reg;
    logic [1:0]            s1_op_reg;
    logic [AW-1:0]         s1_addr_reg;
    logic                  s1_last_reg;
    logic                  s1_empty_reg;
    logic                  s1_inr_reg;

    logic                  fwd_valid_reg;
    logic [AW-1:0]         fwd_addr_reg;
    logic [COUNT_BITS-1:0] fwd_cnt_reg;

    logic                  chg_reg;
    logic                  mat_reg;
    logic                  chg_next;
    logic                  mat_next;

    logic                  out_valid_reg;
    logic                  present_reg;
    logic [7:0]            use_count_reg;
    logic                  map_changed_reg;
    logic                  any_match_reg;
    logic                  set_done_reg;
    logic [1:0]            status_reg;

    logic                  s1_move;
    logic                  in_take;
    logic                  in_range;
    logic [COUNT_BITS-1:0] old_cnt;
    logic [COUNT_BITS-1:0] new_cnt;
    upd_flags_t            flags;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [COUNT_BITS-1:0] wr_data;
    logic [COUNT_BITS+7:0] cnt_ext;

    assign s1_move  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = clear_reg || (s1_valid_reg && !s1_move);
    assign in_take  = in_valid && !in_stall;
    assign in_range = ({16'b0, type_id} < 32'(TYPE_COUNT));

    // last write-back is newer than what the memory returned for this word
    assign old_cnt = (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg)) ? fwd_cnt_reg
                                                                      : rd_data_reg;

    rtpm_update #(
        .COUNT_BITS (COUNT_BITS)
    ) u_update (
        .op       (op_t'(s1_op_reg)),
        .empty    (s1_empty_reg),
        .in_range (s1_inr_reg),
        .old_cnt  (old_cnt),
        .new_cnt  (new_cnt),
        .flags    (flags)
    );

    assign wr_en   = clear_reg || (s1_move && flags.wr_en);
    assign wr_addr = clear_reg ? clr_addr_reg : s1_addr_reg;
    assign wr_data = clear_reg ? '0 : new_cnt;
    assign cnt_ext = {8'b0, new_cnt};

    assign chg_next = chg_reg || flags.flip;
    assign mat_next = mat_reg || flags.hit;

    // count memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (in_take)
        begin
            rd_data_reg <= mem[type_id[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg     <= 1'b1;
            clr_addr_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            chg_reg       <= 1'b0;
            mat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clear_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(TYPE_COUNT - 1))
                begin
                    clear_reg <= 1'b0;
                end
            end
            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move && flags.wr_en)
            begin
                fwd_valid_reg <= 1'b1;
            end
            if (s1_move)
            begin
                chg_reg <= s1_last_reg ? 1'b0 : chg_next;
                mat_reg <= s1_last_reg ? 1'b0 : mat_next;
            end
            out_valid_reg <= s1_move || (out_valid_reg && out_stall);
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_op_reg    <= opcode;
            s1_addr_reg  <= type_id[AW-1:0];
            s1_last_reg  <= last_in_set;
            s1_empty_reg <= empty_set;
            s1_inr_reg   <= in_range;
        end
        if (s1_move && flags.wr_en)
        begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_cnt_reg  <= new_cnt;
        end
        if (s1_move)
        begin
            present_reg     <= flags.pres;
            use_count_reg   <= cnt_ext[7:0];
            map_changed_reg <= chg_next;
            any_match_reg   <= mat_next;
            set_done_reg    <= s1_last_reg;
            status_reg      <= flags.status;
        end
    end

    assign out_valid   = out_valid_reg;
    assign present     = present_reg;
    assign use_count   = use_count_reg;
    assign map_changed = map_changed_reg;
    assign any_match   = any_match_reg;
    assign set_done    = set_done_reg;
    assign status      = status_reg;

    `RTPM_ASSERT_ALWAYS(a_clear_pipe_empty, (rst_n && clear_reg) |-> (!s1_valid_reg && !out_valid_reg), "word in flight during clearing pass")
    `RTPM_ASSERT(a_s1_hold, (s1_valid_reg && !s1_move) |=> (s1_valid_reg && $stable(s1_addr_reg) && $stable(rd_data_reg)), "held word lost its address or read data")
    `RTPM_ASSERT(a_set_end_clears, (s1_move && s1_last_reg) |=> (!chg_reg && !mat_reg), "set flags not cleared after last word")

endmodule

[rtl/rtpm_update.sv]
// count update for one word: saturating add, guarded remove, test, read
module rtpm_update
    import rtpm_pkg::*;
#(
    parameter int COUNT_BITS = 8
)
(
    input  op_t                   op,
    input  logic                  empty,
    input  logic                  in_range,
    input  logic [COUNT_BITS-1:0] old_cnt,
    output logic [COUNT_BITS-1:0] new_cnt,
    output upd_flags_t            flags
);

    localparam logic [COUNT_BITS-1:0] CntMax = {COUNT_BITS{1'b1}};

    always_comb
    begin
        new_cnt      = '0;
        flags.status = ST_OK;
        flags.pres   = 1'b0;
        flags.flip   = 1'b0;
        flags.hit    = 1'b0;
        flags.wr_en  = 1'b0;
        if (empty)
        begin
            // an empty test set matches everything
            flags.hit = (op == OP_TEST);
        end
        else if (in_range)
        begin
            new_cnt = old_cnt;
            case (op)
                OP_ADD:
                begin
                    if (old_cnt == CntMax)
                    begin
                        flags.status = ST_SAT;
                    end
                    else
                    begin
                        new_cnt     = old_cnt + 1'b1;
                        flags.flip  = (old_cnt == '0);
                        flags.wr_en = 1'b1;
                    end
                end
                OP_REMOVE:
                begin
                    if (old_cnt == '0)
                    begin
                        flags.status = ST_ZERO;
                    end
                    else
                    begin
                        new_cnt     = old_cnt - 1'b1;
                        flags.flip  = (old_cnt == COUNT_BITS'(1));
                        flags.wr_en = 1'b1;
                    end
                end
                OP_TEST:
                begin
                    flags.hit = (old_cnt != '0);
                end
                default:
                begin
                    // read only
                end
            endcase
            // presence bit always tracks a nonzero count
            flags.pres = (new_cnt != '0);
        end
    end

endmodule
